@@ sv/smpq_pkg.sv @@
// shared types, codes and defaults for the sorted minimum priority queue
package smpq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 32;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned COUNT_OUT_W   = 6;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_e;

  // broadcast to every cell for one request
  typedef struct packed {
    logic                      ins;
    logic                      rem;
    logic signed [VALUE_W-1:0] val;
  } cell_ctrl_t;

endpackage

@@ sv/smpq_cell.sv @@
// one storage cell of the sorted row: compare with the new value and shift
module smpq_cell (
  input  logic                              clk_i,
  input  smpq_pkg::cell_ctrl_t              ctrl_i,
  input  logic                              occ_i,
  input  logic                              at_tail_i,
  input  logic                              left_gt_i,
  input  logic signed [smpq_pkg::VALUE_W-1:0] left_val_i,
  input  logic signed [smpq_pkg::VALUE_W-1:0] right_val_i,
  output logic                              gt_o,
  output logic signed [smpq_pkg::VALUE_W-1:0] val_o
);
  import smpq_pkg::*;

  logic signed [VALUE_W-1:0] val_q, val_d;

  // stored value is strictly greater than the new one, so it moves towards the tail
  assign gt_o  = occ_i && (ctrl_i.val < val_q);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins && (gt_o || at_tail_i)) begin
      val_d = left_gt_i ? left_val_i : ctrl_i.val;
    end else if (ctrl_i.rem) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

@@ sv/sorted_min_priority_queue.sv @@
// sorted minimum priority queue: row of compare-and-shift cells, registered result
// an accepted request has its result in the output register in the next cycle
// throughput: one request per cycle while the output is not stalled, set by the compare and shift in each cell
// a new request is taken in the cycle the held result leaves
// reset clears the entry count and the output valid; cell contents stay undefined
module sorted_min_priority_queue #(
  parameter int unsigned DEPTH = smpq_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                action_i,
  input  logic signed [smpq_pkg::VALUE_W-1:0] item_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic signed [smpq_pkg::VALUE_W-1:0] removed_value_o,
  output logic [smpq_pkg::COUNT_OUT_W-1:0]    entry_count_o
);
  import smpq_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count_q, count_d;
  logic             in_acc, full, empty;
  cell_ctrl_t       ctrl;

  logic [DEPTH-1:0]          gt;
  logic signed [VALUE_W-1:0] cell_val [DEPTH];

  logic                      out_valid_q;
  status_e                   status_q, status_d;
  logic signed [VALUE_W-1:0] removed_q, removed_d;
  logic [COUNT_OUT_W-1:0]    ecount_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CNT_W'(DEPTH));
  assign empty      = (count_q == '0);

  assign ctrl.ins = in_acc && (action_i == ACT_INSERT) && !full;
  assign ctrl.rem = in_acc && (action_i == ACT_REMOVE) && !empty;
  assign ctrl.val = item_value_i;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                      left_gt;
    logic signed [VALUE_W-1:0] left_val, right_val;

    if (i == 0) begin : g_head
      assign left_gt  = 1'b0;
      assign left_val = '0;
    end else begin : g_mid
      assign left_gt  = gt[i-1];
      assign left_val = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_inner
      assign right_val = cell_val[i+1];
    end

    smpq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (CNT_W'(i) < count_q),
      .at_tail_i   (CNT_W'(i) == count_q),
      .left_gt_i   (left_gt),
      .left_val_i  (left_val),
      .right_val_i (right_val),
      .gt_o        (gt[i]),
      .val_o       (cell_val[i])
    );
  end

  always_comb begin
    count_d   = count_q;
    status_d  = STATUS_DONE;
    removed_d = '0;
    if (action_i == ACT_INSERT) begin
      if (full) begin
        status_d = STATUS_OVERFLOW;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_d = STATUS_UNDERFLOW;
      end else begin
        removed_d = cell_val[0];
        count_d   = count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      status_q  <= status_d;
      removed_q <= removed_d;
      ecount_q  <= COUNT_OUT_W'(count_d);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign entry_count_o   = ecount_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not grow the count");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == STATUS_OVERFLOW |-> ecount_q == COUNT_OUT_W'(DEPTH))
    else $error("overflow reported while not full");

  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == STATUS_UNDERFLOW |-> ecount_q == '0 && removed_q == '0)
    else $error("underflow reported with entries or a value");

  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted request left no result");

endmodule

@@ dv/sorted_min_priority_queue_tb.sv @@
// testbench for the sorted minimum priority queue: random and directed requests, scoreboard check
module sorted_min_priority_queue_tb;
  import smpq_pkg::*;

  localparam int unsigned QUEUE_DEPTH   = DEPTH_DEFAULT;
  localparam int unsigned RANDOM_ITEMS  = 1250;
  localparam int unsigned DRAIN_LIMIT   = 2000;

  typedef struct {
    status_e                   status;
    logic signed [VALUE_W-1:0] removed;
    logic [COUNT_OUT_W-1:0]    count;
  } queue_result_t;

  // keeps its own sorted copy of the queue and the results still to come out
  class min_queue_tracker;
    logic signed [VALUE_W-1:0] held_values[$];
    queue_result_t             awaited_results[$];
    int unsigned errors;
    int unsigned n_inserts, n_removes, n_overflows, n_underflows, n_checked;
    int unsigned n_equal_keys, peak_count;

    function void note_request(logic act, logic signed [VALUE_W-1:0] val);
      queue_result_t r;
      int unsigned   pos;
      r.status  = STATUS_DONE;
      r.removed = '0;
      if (act == ACT_INSERT) begin
        n_inserts++;
        if (held_values.size() >= QUEUE_DEPTH) begin
          r.status = STATUS_OVERFLOW;
          n_overflows++;
        end else begin
          // goes behind every stored value less than or equal to it
          pos = held_values.size();
          for (int i = 0; i < held_values.size(); i++) begin
            if (held_values[i] == val) n_equal_keys++;
            if (val < held_values[i]) begin
              pos = i;
              break;
            end
          end
          held_values.insert(pos, val);
        end
      end else begin
        n_removes++;
        if (held_values.size() == 0) begin
          r.status = STATUS_UNDERFLOW;
          n_underflows++;
        end else begin
          r.removed = held_values.pop_front();
        end
      end
      if (held_values.size() > peak_count) peak_count = held_values.size();
      r.count = COUNT_OUT_W'(held_values.size());
      awaited_results.push_back(r);
    endfunction

    function void check_result(logic [1:0] status, logic signed [VALUE_W-1:0] removed,
                               logic [COUNT_OUT_W-1:0] count);
      queue_result_t e;
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing awaited: status %0d removed %0d count %0d",
                 $time, status, removed, count);
        return;
      end
      e = awaited_results.pop_front();
      n_checked++;
      if (status !== e.status) begin
        errors++;
        $display("%0t: status mismatch, expected %0d got %0d", $time, e.status, status);
      end
      if (removed !== e.removed) begin
        errors++;
        $display("%0t: removed_value mismatch, expected %0d got %0d", $time, e.removed, removed);
      end
      if (count !== e.count) begin
        errors++;
        $display("%0t: entry_count mismatch, expected %0d got %0d", $time, e.count, count);
      end
    endfunction

    function int unsigned outstanding();
      return awaited_results.size();
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic                      action_i = ACT_INSERT;
  logic signed [VALUE_W-1:0] item_value_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [1:0]                status_o;
  logic signed [VALUE_W-1:0] removed_value_o;
  logic [COUNT_OUT_W-1:0]    entry_count_o;

  min_queue_tracker pq_model = new();
  int unsigned      requests_sent;

  sorted_min_priority_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .item_value_i   (item_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .removed_value_o(removed_value_o),
    .entry_count_o  (entry_count_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // results are checked before the request taken at the same edge is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        pq_model.check_result(status_o, removed_value_o, entry_count_o);
      if (in_valid_i && !in_stall_o)
        pq_model.note_request(action_i, item_value_i);
    end
  end

  // receiver: free-flowing, light, heavy and periodic stall modes, picked at random for each spell
  int unsigned stall_mode, mode_left, cycle_no;
  always @(posedge clk_i) begin
    cycle_no <= cycle_no + 1;
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 99) < 30);
      2:       out_stall_i <= ($urandom_range(0, 99) < 80);
      default: out_stall_i <= (cycle_no % 5 >= 3);
    endcase
  end

  task automatic send_request(input logic act, input logic signed [VALUE_W-1:0] val);
    in_valid_i   <= 1'b1;
    action_i     <= act;
    item_value_i <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    requests_sent++;
  endtask

  task automatic hold_off(input int unsigned n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_drain();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pq_model.outstanding() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  // small range for equal keys, the extremes, else any 32-bit pattern
  function automatic logic signed [VALUE_W-1:0] choose_value();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) return $urandom_range(0, 6) - 3;
    if (pick < 35) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh7FFF_FFFF;
        1:       return 32'sh8000_0000;
        2:       return '0;
        default: return -1;
      endcase
    end
    return $urandom();
  endfunction

  initial begin
    int unsigned random_sent, phase_len, insert_pct, burst, phase_no;
    bit          steady;
    logic        act;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty remove, extremes, equal keys, drain past empty
    send_request(ACT_REMOVE, 32'sh5A5A_A5A5);
    send_request(ACT_INSERT, 32'sh7FFF_FFFF);
    send_request(ACT_INSERT, 32'sh8000_0000);
    send_request(ACT_INSERT, 32'sh0000_0000);
    send_request(ACT_INSERT, -32'sd1);
    send_request(ACT_INSERT, 32'sd5);
    send_request(ACT_INSERT, 32'sd5);
    send_request(ACT_INSERT, 32'sh7FFF_FFFF);
    send_request(ACT_INSERT, 32'sh8000_0000);
    repeat (9) send_request(ACT_REMOVE, $urandom());
    send_request(ACT_INSERT, 32'sd1);
    send_request(ACT_REMOVE, -32'sd1);
    wait_for_drain();

    random_sent = 0;
    phase_no    = 0;
    while (random_sent < RANDOM_ITEMS) begin
      // the first phase fills the queue so that overflow is reached early
      if (phase_no == 0) begin
        insert_pct = 85;
        phase_len  = 60;
      end else begin
        case ($urandom_range(0, 2))
          0:       insert_pct = 85;
          1:       insert_pct = 15;
          default: insert_pct = 50;
        endcase
        phase_len = $urandom_range(20, 80);
      end
      steady = ($urandom_range(0, 3) == 0);
      while (phase_len > 0) begin
        burst = $urandom_range(1, 16);
        while (burst > 0 && phase_len > 0) begin
          act = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
          send_request(act, choose_value());
          burst--;
          phase_len--;
          random_sent++;
        end
        if (!steady) hold_off(($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6));
      end
      if (phase_no % 4 == 1) wait_for_drain();
      phase_no++;
    end

    wait_for_drain();
    repeat (4) @(posedge clk_i);
    if (pq_model.outstanding() != 0) begin
      pq_model.errors++;
      $display("%0t: %0d results never arrived", $time, pq_model.outstanding());
    end

    $display("covered %0d requests: %0d inserts (%0d overflow, %0d behind equal keys), %0d removes",
             requests_sent, pq_model.n_inserts, pq_model.n_overflows, pq_model.n_equal_keys,
             pq_model.n_removes);
    $display("%0d underflow, peak occupancy %0d of %0d, %0d results checked",
             pq_model.n_underflows, pq_model.peak_count, QUEUE_DEPTH, pq_model.n_checked);
    if (pq_model.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d results outstanding", pq_model.outstanding());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/smpq_pkg.sv
sv/smpq_cell.sv
sv/sorted_min_priority_queue.sv
dv/sorted_min_priority_queue_tb.sv
